### design/btb2l_pkg.sv
// Shared types, constants and helpers for the two-level branch target buffer.
package btb2l_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int IDX_W       = 5;
	localparam int MAX_HISTORY = 8;
	localparam int TAG_WIDTH   = 30;
	localparam int EPOCH_W     = 4;
	localparam int ROW_SIZE    = 1 << MAX_HISTORY;
	localparam int LCTR_DEPTH  = MAX_ENTRIES * ROW_SIZE;
	localparam int LADDR_W     = IDX_W + MAX_HISTORY;

	localparam logic KIND_PREDICT = 1'b0;
	localparam logic KIND_UPDATE  = 1'b1;

	typedef enum logic [2:0] {
		REG_INDEX_BITS = 3'd0,
		REG_TAG_BITS   = 3'd1,
		REG_HIST_BITS  = 3'd2,
		REG_GLOBAL_HIST = 3'd3,
		REG_GLOBAL_TAB = 3'd4,
		REG_SHARE_MODE = 3'd5,
		REG_INIT_CTR   = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SHARE_HIST    = 2'd0,
		SHARE_PC_LOW  = 2'd1,
		SHARE_PC_HIGH = 2'd2
	} share_mode_t;

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_RD,
		S_WB,
		S_ROWCLR
	} state_t;

	// One word of the per-entry counter memory: the counter and the row epoch it was written in.
	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [1:0]         ctr;
	} lword_t;

	function automatic logic [1:0] ctr_train(input logic [1:0] c, input logic t);
		logic [1:0] r;
		r = c;
		if (t) begin
			if (c != 2'd3) r = c + 2'd1;
		end else begin
			if (c != 2'd0) r = c - 2'd1;
		end
		return r;
	endfunction

endpackage

### design/btb2l_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module btb2l_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### design/btb_two_level_branch_predictor_unit.sv
// Top level of the two-level branch target buffer with counter memories.
//
// Usage: items arrive on the s_ channel (tuser = kind: 0 predict, 1 update)
// and each item yields exactly one result beat on the m_ channel. A predict
// beat returns the direction and target; an update beat trains the entry,
// reports whether the earlier prediction must be flushed, and every result
// carries the running branch and flush totals.
// Each item is read from the counter memories in S_RD and written back in S_WB,
// where its result is registered; no new item is taken before the last one
// writes back, since the read-modify-write of the counter word sets that limit.
// An allocating update whose row epoch has run out adds a sweep of that
// counter row (S_ROWCLR) before the next item is taken.
// After reset, and after every configuration write to registers 0 to 6, the
// block runs a clearing pass over the counter memories with s_tready low;
// configuration writes are taken at any time (cfg_ready is always high).
// When the receiver stalls, the finished result waits in the output
// register and the block stops after reading the next item until it drains.
module btb_two_level_branch_predictor_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] pc, [63:32] target_pc, [64] taken, [96:65] predicted_dst, zero pad
	input  logic [103:0] s_tdata,
	// [0] kind
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] predicted_taken, [32:1] predicted_target, [33] flush,
	// [65:34] branch_count, [97:66] flush_count, zero pad
	output logic [103:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [7:0]   cfg_data
);

	localparam int IW = btb2l_pkg::IDX_W;
	localparam int HW = btb2l_pkg::MAX_HISTORY;
	localparam int TW = btb2l_pkg::TAG_WIDTH;
	localparam int EW = btb2l_pkg::EPOCH_W;
	localparam int NE = btb2l_pkg::MAX_ENTRIES;
	localparam int LW = btb2l_pkg::LADDR_W;

	btb2l_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [2:0] idx_bits_q;
	logic [4:0] tag_bits_q;
	logic [3:0] hist_bits_q;
	logic       ghist_q, gtab_q;
	logic [1:0] smode_q, init_q;

	// Item held from acceptance until write-back.
	logic        kind_s1, taken_s1;
	logic [31:0] pc_s1, tgt_s1, pdst_s1;

	// Values looked up in the read cycle.
	logic [IW-1:0] idx_s2;
	logic [TW-1:0] tag_s2;
	logic          hit_s2, alloc_s2;
	logic [HW-1:0] hbase_s2;
	logic [LW-1:0] laddr_s2;
	logic [HW-1:0] saddr_s2;

	// Entry table.
	logic [NE-1:0] valid_q;
	logic [TW-1:0] tag_q [NE];
	logic [31:0]   target_q [NE];
	logic [HW-1:0] lhist_q [NE];
	logic [EW-1:0] epoch_q [NE];
	logic [HW-1:0] shist_q;

	logic [31:0] bcnt_q, fcnt_q;
	logic        out_valid_q, o_ptaken_q, o_flush_q;
	logic [31:0] o_ptarget_q;

	logic [LW-1:0]          clr_q;
	logic                   lw_pend_q;
	btb2l_pkg::lword_t      trained_q;

	// Memory ports.
	logic                   l_we, s_we;
	logic [LW-1:0]          l_waddr;
	btb2l_pkg::lword_t      l_wdata, l_rdata;
	logic [HW-1:0]          s_waddr;
	logic [1:0]             s_wdata, s_rdata;

	logic cfg_wr;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && (cfg_index <= 3'(btb2l_pkg::REG_INIT_CTR));

	// Derived configuration.
	logic [2:0]    eb;
	logic [4:0]    tb;
	logic [3:0]    hl;
	logic [IW-1:0] idx_mask;
	logic [TW-1:0] tmask;
	logic [HW-1:0] hmask;

	always_comb begin
		eb = (idx_bits_q > 3'd5) ? 3'd5 : idx_bits_q;
		tb = (tag_bits_q > 5'(TW)) ? 5'(TW) : tag_bits_q;
		if (hist_bits_q == 4'd0) hl = 4'd1;
		else if (hist_bits_q > 4'(HW)) hl = 4'(HW);
		else hl = hist_bits_q;
		idx_mask = IW'((33'd1 << eb) - 33'd1);
		tmask    = TW'((33'd1 << tb) - 33'd1);
		hmask    = HW'((33'd1 << hl) - 33'd1);
	end

	// Read cycle: index, tag, hit and counter addresses.
	logic [29:0]   pcw;
	logic [IW-1:0] idx_rd;
	logic [TW-1:0] tag_rd;
	logic          hit_rd, alloc_rd;
	logic [HW-1:0] lh_rd, hbase_rd, hsel_rd, saddr_rd;
	logic [LW-1:0] laddr_rd;

	always_comb begin
		pcw      = pc_s1[31:2];
		idx_rd   = pcw[IW-1:0] & idx_mask;
		tag_rd   = TW'(pcw >> eb) & tmask;
		hit_rd   = valid_q[idx_rd] && (tag_q[idx_rd] == tag_rd);
		alloc_rd = (kind_s1 == btb2l_pkg::KIND_UPDATE) && !hit_rd;
		lh_rd    = alloc_rd ? '0 : lhist_q[idx_rd];
		hbase_rd = ghist_q ? shist_q : lh_rd;
		hsel_rd  = hbase_rd & hmask;
		case (btb2l_pkg::share_mode_t'(smode_q))
			btb2l_pkg::SHARE_PC_LOW:  saddr_rd = (pc_s1[HW+1:2] & hmask) ^ hsel_rd;
			btb2l_pkg::SHARE_PC_HIGH: saddr_rd = (pc_s1[HW+15:16] & hmask) ^ hsel_rd;
			default:                  saddr_rd = hsel_rd;
		endcase
		laddr_rd = {idx_rd, hsel_rd};
	end

	// Write-back cycle.
	logic          is_upd, can_emit, wb_go, wrap;
	logic [1:0]    lctr, ctr_old, ctr_new;
	logic [EW-1:0] cur_epoch, new_epoch;
	logic [31:0]   pc_plus4;
	logic          pred_taken, flush_wb;
	logic [HW-1:0] hist_new;

	always_comb begin
		is_upd     = (kind_s1 == btb2l_pkg::KIND_UPDATE);
		can_emit   = !out_valid_q || m_tready;
		wb_go      = (state_q == btb2l_pkg::S_WB) && can_emit;
		cur_epoch  = epoch_q[idx_s2];
		wrap       = alloc_s2 && (cur_epoch == {EW{1'b1}});
		if (!alloc_s2) new_epoch = cur_epoch;
		else if (wrap) new_epoch = '0;
		else new_epoch = cur_epoch + EW'(1);
		// A stale epoch means the row was reloaded since that word was written.
		lctr = (alloc_s2 || (l_rdata.epoch != cur_epoch)) ? init_q : l_rdata.ctr;
		ctr_old    = gtab_q ? s_rdata : lctr;
		ctr_new    = btb2l_pkg::ctr_train(ctr_old, taken_s1);
		pc_plus4   = pc_s1 + 32'd4;
		pred_taken = hit_s2 && ctr_old[1];
		flush_wb   = is_upd && ((!taken_s1 && (pdst_s1 != pc_plus4)) ||
			(taken_s1 && (pdst_s1 != tgt_s1)));
		hist_new   = {hbase_s2[HW-2:0], taken_s1} & hmask;
	end

	assign s_tready = (state_q == btb2l_pkg::S_IDLE) || (wb_go && !wrap);

	// Counter memory write selection.
	always_comb begin
		l_we    = 1'b0;
		l_waddr = laddr_s2;
		l_wdata = '{epoch: new_epoch, ctr: ctr_new};
		s_we    = 1'b0;
		s_waddr = saddr_s2;
		s_wdata = ctr_new;
		case (state_q)
			btb2l_pkg::S_CLR: begin
				l_we    = 1'b1;
				l_waddr = clr_q;
				l_wdata = '{epoch: '0, ctr: init_q};
				s_we    = 1'b1;
				s_waddr = clr_q[HW-1:0];
				s_wdata = init_q;
			end
			btb2l_pkg::S_ROWCLR: begin
				l_we    = 1'b1;
				l_waddr = {idx_s2, clr_q[HW-1:0]};
				if (lw_pend_q && (clr_q[HW-1:0] == laddr_s2[HW-1:0])) l_wdata = trained_q;
				else l_wdata = '{epoch: '0, ctr: init_q};
			end
			btb2l_pkg::S_WB: begin
				l_we = wb_go && is_upd && !gtab_q && !wrap;
				s_we = wb_go && is_upd && gtab_q;
			end
			default: begin
			end
		endcase
	end

	btb2l_ram #(
		.DEPTH(btb2l_pkg::LCTR_DEPTH),
		.WIDTH($bits(btb2l_pkg::lword_t))
	) u_lctr (
		.clk  (clk),
		.we   (l_we),
		.waddr(l_waddr),
		.wdata(l_wdata),
		.raddr(laddr_rd),
		.rdata(l_rdata)
	);

	btb2l_ram #(
		.DEPTH(btb2l_pkg::ROW_SIZE),
		.WIDTH(2)
	) u_sctr (
		.clk  (clk),
		.we   (s_we),
		.waddr(s_waddr),
		.wdata(s_wdata),
		.raddr(saddr_rd),
		.rdata(s_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			btb2l_pkg::S_CLR: begin
				if (clr_q == {LW{1'b1}}) state_d = btb2l_pkg::S_IDLE;
			end
			btb2l_pkg::S_IDLE: begin
				if (s_tvalid) state_d = btb2l_pkg::S_RD;
			end
			btb2l_pkg::S_RD: begin
				state_d = btb2l_pkg::S_WB;
			end
			btb2l_pkg::S_WB: begin
				if (wb_go) begin
					if (wrap) state_d = btb2l_pkg::S_ROWCLR;
					else if (s_tvalid) state_d = btb2l_pkg::S_RD;
					else state_d = btb2l_pkg::S_IDLE;
				end
			end
			btb2l_pkg::S_ROWCLR: begin
				if (clr_q[HW-1:0] == {HW{1'b1}}) state_d = btb2l_pkg::S_IDLE;
			end
			default: state_d = btb2l_pkg::S_CLR;
		endcase
		if (cfg_wr) state_d = btb2l_pkg::S_CLR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btb2l_pkg::S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Sweep counter, configuration and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			idx_bits_q  <= 3'd0;
			tag_bits_q  <= 5'd0;
			hist_bits_q <= 4'd1;
			ghist_q     <= 1'b0;
			gtab_q      <= 1'b0;
			smode_q     <= 2'd0;
			init_q      <= 2'd1;
			valid_q     <= '0;
			shist_q     <= '0;
			bcnt_q      <= '0;
			fcnt_q      <= '0;
			out_valid_q <= 1'b0;
			lw_pend_q   <= 1'b0;
			for (int i = 0; i < NE; i++) begin
				lhist_q[i] <= '0;
				epoch_q[i] <= '0;
			end
		end else begin
			if (state_q == btb2l_pkg::S_CLR || state_q == btb2l_pkg::S_ROWCLR) begin
				clr_q <= clr_q + LW'(1);
			end
			if (wb_go) begin
				out_valid_q <= 1'b1;
				if (wrap) clr_q <= '0;
				if (is_upd) begin
					bcnt_q          <= bcnt_q + 32'd1;
					valid_q[idx_s2] <= 1'b1;
					epoch_q[idx_s2] <= new_epoch;
					lw_pend_q       <= !gtab_q;
					if (flush_wb) fcnt_q <= fcnt_q + 32'd1;
					if (ghist_q) begin
						shist_q <= hist_new;
						if (alloc_s2) lhist_q[idx_s2] <= '0;
					end else begin
						lhist_q[idx_s2] <= hist_new;
					end
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				unique case (btb2l_pkg::cfg_reg_t'(cfg_index))
					btb2l_pkg::REG_INDEX_BITS:  idx_bits_q  <= cfg_data[2:0];
					btb2l_pkg::REG_TAG_BITS:    tag_bits_q  <= cfg_data[4:0];
					btb2l_pkg::REG_HIST_BITS:   hist_bits_q <= cfg_data[3:0];
					btb2l_pkg::REG_GLOBAL_HIST: ghist_q     <= cfg_data[0];
					btb2l_pkg::REG_GLOBAL_TAB:  gtab_q      <= cfg_data[0];
					btb2l_pkg::REG_SHARE_MODE:  smode_q     <= cfg_data[1:0];
					btb2l_pkg::REG_INIT_CTR:    init_q      <= cfg_data[1:0];
					default: begin
					end
				endcase
				clr_q   <= '0;
				valid_q <= '0;
				shist_q <= '0;
				for (int i = 0; i < NE; i++) begin
					lhist_q[i] <= '0;
					epoch_q[i] <= '0;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1  <= s_tuser;
			pc_s1    <= s_tdata[31:0];
			tgt_s1   <= s_tdata[63:32];
			taken_s1 <= s_tdata[64];
			pdst_s1  <= s_tdata[96:65];
		end
		if (state_q == btb2l_pkg::S_RD) begin
			idx_s2   <= idx_rd;
			tag_s2   <= tag_rd;
			hit_s2   <= hit_rd;
			alloc_s2 <= alloc_rd;
			hbase_s2 <= hbase_rd;
			laddr_s2 <= laddr_rd;
			saddr_s2 <= saddr_rd;
		end
		if (wb_go) begin
			o_ptaken_q  <= !is_upd && pred_taken;
			o_ptarget_q <= is_upd ? 32'd0 : (pred_taken ? target_q[idx_s2] : pc_plus4);
			o_flush_q   <= flush_wb;
			trained_q   <= '{epoch: '0, ctr: ctr_new};
			if (is_upd) begin
				tag_q[idx_s2]    <= tag_s2;
				target_q[idx_s2] <= tgt_s1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, fcnt_q, bcnt_q, o_flush_q, o_ptarget_q, o_ptaken_q};

	// No item is taken while the counter memories are being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == btb2l_pkg::S_CLR) |-> !s_tready)
		else $error("item accepted during clearing pass");

	// A row sweep writes only the row of the allocated entry.
	a_rowclr_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == btb2l_pkg::S_ROWCLR) |-> (l_we && (l_waddr[LW-1:HW] == idx_s2)))
		else $error("row sweep outside its row");

	// A finished write-back always leaves a result in the output register.
	a_wb_emits: assert property (@(posedge clk) disable iff (!arst_n)
		wb_go |=> out_valid_q)
		else $error("write-back lost its result");

endmodule

### tb/testbench.sv
// Self-checking testbench for the two-level branch target buffer top level.
module testbench;

	localparam logic [2:0] UNUSED_REG = 3'd7;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 86;
	localparam int POOL = 8;
	localparam logic K_PRED = btb2l_pkg::KIND_PREDICT;
	localparam logic K_UPD  = btb2l_pkg::KIND_UPDATE;

	typedef struct {
		bit        kind;
		bit [31:0] pc;
		bit [31:0] tgt;
		bit        tk;
		bit [31:0] pdst;
	} branch_item_t;

	typedef struct {
		bit        ptaken;
		bit [31:0] ptarget;
		bit        flush;
		bit [31:0] bcnt;
		bit [31:0] fcnt;
	} branch_result_t;

	typedef struct {
		branch_item_t   item;
		bit             known;
		branch_result_t res;
	} directed_row_t;

	// Register settings per phase: index, tag, history, global history,
	// global table, share mode, initial counter. Phase 0 is the reset setting.
	typedef bit [7:0] setting_t [7];

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [103:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [7:0]   cfg_data = '0;

	btb_two_level_branch_predictor_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the block's configuration and tables.
	bit [2:0]  sh_index_bits;
	bit [4:0]  sh_tag_bits;
	bit [3:0]  sh_hist_bits;
	bit        sh_global_hist;
	bit        sh_global_tab;
	bit [1:0]  sh_share_mode;
	bit [1:0]  sh_init_ctr;
	bit        sh_valid [btb2l_pkg::MAX_ENTRIES];
	bit [29:0] sh_tag [btb2l_pkg::MAX_ENTRIES];
	bit [31:0] sh_target [btb2l_pkg::MAX_ENTRIES];
	bit [7:0]  sh_local_hist [btb2l_pkg::MAX_ENTRIES];
	bit [7:0]  sh_shared_hist;
	bit [1:0]  sh_local_ctr [btb2l_pkg::MAX_ENTRIES][btb2l_pkg::ROW_SIZE];
	bit [1:0]  sh_shared_ctr [btb2l_pkg::ROW_SIZE];
	bit [31:0] sh_branches;
	bit [31:0] sh_flushes;

	branch_result_t pending_results [$];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	bit [31:0] pc_pool [POOL];
	bit [31:0] tgt_pool [POOL];

	function automatic void reload_tables();
		for (int i = 0; i < btb2l_pkg::MAX_ENTRIES; i++) begin
			sh_valid[i] = 1'b0;
			sh_tag[i] = '0;
			sh_target[i] = '0;
			sh_local_hist[i] = '0;
			for (int j = 0; j < btb2l_pkg::ROW_SIZE; j++) sh_local_ctr[i][j] = sh_init_ctr;
		end
		sh_shared_hist = '0;
		for (int j = 0; j < btb2l_pkg::ROW_SIZE; j++) sh_shared_ctr[j] = sh_init_ctr;
	endfunction

	function automatic void apply_register(bit [2:0] idx, bit [7:0] v);
		case (idx)
			btb2l_pkg::REG_INDEX_BITS:  sh_index_bits = v[2:0];
			btb2l_pkg::REG_TAG_BITS:    sh_tag_bits = v[4:0];
			btb2l_pkg::REG_HIST_BITS:   sh_hist_bits = v[3:0];
			btb2l_pkg::REG_GLOBAL_HIST: sh_global_hist = v[0];
			btb2l_pkg::REG_GLOBAL_TAB:  sh_global_tab = v[0];
			btb2l_pkg::REG_SHARE_MODE:  sh_share_mode = v[1:0];
			btb2l_pkg::REG_INIT_CTR:    sh_init_ctr = v[1:0];
			default: return;
		endcase
		reload_tables();
	endfunction

	function automatic bit [31:0] entry_total();
		return 32'd1 << ((sh_index_bits > 3'd5) ? 5 : sh_index_bits);
	endfunction

	function automatic bit [7:0] hist_mask();
		int h;
		h = sh_hist_bits;
		if (h < 1) h = 1;
		if (h > btb2l_pkg::MAX_HISTORY) h = btb2l_pkg::MAX_HISTORY;
		return 8'((32'd1 << h) - 1);
	endfunction

	function automatic bit [1:0] ctr_step(bit [1:0] c, bit up);
		if (up) return (c == 2'd3) ? c : c + 2'd1;
		return (c == 2'd0) ? c : c - 2'd1;
	endfunction

	// Predicts one item and moves the shadow state along as the block would.
	function automatic branch_result_t predict_branch(branch_item_t it);
		branch_result_t r;
		bit [31:0] n, idx, tag, tmask;
		bit [7:0] h, sidx;
		bit hit;
		int t;
		n = entry_total();
		idx = (it.pc >> 2) % n;
		t = (sh_tag_bits > btb2l_pkg::TAG_WIDTH) ? btb2l_pkg::TAG_WIDTH : sh_tag_bits;
		tmask = (32'd1 << t) - 1;
		tag = ((it.pc >> 2) / n) & tmask;
		hit = sh_valid[idx] && (sh_tag[idx] == 30'(tag));
		r = '{default: 0};
		if (it.kind == K_UPD) begin
			sh_branches++;
			if (!hit) begin
				sh_valid[idx] = 1'b1;
				sh_tag[idx] = 30'(tag);
				sh_local_hist[idx] = '0;
				for (int j = 0; j < btb2l_pkg::ROW_SIZE; j++)
					sh_local_ctr[idx][j] = sh_init_ctr;
			end
		end
		h = (sh_global_hist ? sh_shared_hist : sh_local_hist[idx]) & hist_mask();
		if (sh_share_mode == btb2l_pkg::SHARE_PC_LOW)
			sidx = (8'(it.pc >> 2) & hist_mask()) ^ h;
		else if (sh_share_mode == btb2l_pkg::SHARE_PC_HIGH)
			sidx = (8'(it.pc >> 16) & hist_mask()) ^ h;
		else sidx = h;
		if (it.kind == K_PRED) begin
			r.ptarget = it.pc + 32'd4;
			if (hit && ((sh_global_tab ? sh_shared_ctr[sidx] : sh_local_ctr[idx][h]) >= 2'd2))
			begin
				r.ptaken = 1'b1;
				r.ptarget = sh_target[idx];
			end
		end else begin
			if (sh_global_tab) sh_shared_ctr[sidx] = ctr_step(sh_shared_ctr[sidx], it.tk);
			else sh_local_ctr[idx][h] = ctr_step(sh_local_ctr[idx][h], it.tk);
			if (sh_global_hist) sh_shared_hist = {sh_shared_hist[6:0], it.tk} & hist_mask();
			else sh_local_hist[idx] = {sh_local_hist[idx][6:0], it.tk} & hist_mask();
			sh_target[idx] = it.tgt;
			if ((!it.tk && it.pdst != it.pc + 32'd4) || (it.tk && it.pdst != it.tgt)) begin
				r.flush = 1'b1;
				sh_flushes++;
			end
		end
		r.bcnt = sh_branches;
		r.fcnt = sh_flushes;
		return r;
	endfunction

	// Mostly branches from a small address pool so that entries hit and train.
	function automatic branch_item_t make_branch();
		branch_item_t it;
		int p, sel;
		p = $urandom_range(POOL - 1);
		it.kind = $urandom_range(1);
		it.tk = $urandom_range(1);
		it.pc = ($urandom_range(99) < 75) ? pc_pool[p] : $urandom;
		it.tgt = ($urandom_range(99) < 70) ? tgt_pool[p] : $urandom;
		sel = $urandom_range(99);
		if (sel < 40) it.pdst = it.tgt;
		else if (sel < 70) it.pdst = it.pc + 32'd4;
		else it.pdst = $urandom;
		return it;
	endfunction

	task automatic write_register(bit [2:0] idx, bit [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_register(idx, v);
		@(negedge clk);
	endtask

	// Offers one beat, possibly after idle cycles, and logs its expectation.
	task automatic send_branch(branch_item_t it, bit known, branch_result_t res);
		branch_result_t r;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.kind;
		s_tdata <= {7'd0, it.pdst, it.tk, it.tgt, it.pc};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = predict_branch(it);
		pending_results.push_back(known ? res : r);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	// Receiver side: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = 200;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		branch_result_t e;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected: %h", $time, m_tdata);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (m_tdata[0] !== e.ptaken) begin
					$display("%0t: predicted_taken exp %0d got %0d", $time, e.ptaken, m_tdata[0]);
					errors++;
				end
				if (m_tdata[32:1] !== e.ptarget) begin
					$display("%0t: predicted_target exp %h got %h", $time, e.ptarget,
						m_tdata[32:1]);
					errors++;
				end
				if (m_tdata[33] !== e.flush) begin
					$display("%0t: flush exp %0d got %0d", $time, e.flush, m_tdata[33]);
					errors++;
				end
				if (m_tdata[65:34] !== e.bcnt) begin
					$display("%0t: branch_count exp %0d got %0d", $time, e.bcnt, m_tdata[65:34]);
					errors++;
				end
				if (m_tdata[97:66] !== e.fcnt) begin
					$display("%0t: flush_count exp %0d got %0d", $time, e.fcnt, m_tdata[97:66]);
					errors++;
				end
			end
		end
	end

	initial begin
		#12000000;
		$display("btb_two_level_branch_predictor_unit test failed");
		$finish;
	end

	initial begin
		directed_row_t rows [$];
		setting_t settings [PHASES];
		branch_item_t it;
		branch_result_t none;
		none = '{default: 0};
		// Reset setting: one entry, no tag bits, so every address shares entry 0.
		rows = '{
			'{'{K_PRED, 32'h0, 32'h0, 1'b0, 32'h0}, 1, '{0, 32'h4, 0, 0, 0}},
			'{'{K_PRED, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF}, 1,
				'{0, 32'h0, 0, 0, 0}},
			'{'{K_PRED, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0}, 1, '{0, 32'h3, 0, 0, 0}},
			'{'{K_UPD, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'h4}, 1, '{0, 32'h0, 1, 1, 1}},
			'{'{K_UPD, 32'h10, 32'h0, 1'b0, 32'h14}, 1, '{0, 32'h0, 0, 2, 1}},
			'{'{K_UPD, 32'h20, 32'h40, 1'b0, 32'h0}, 1, '{0, 32'h0, 1, 3, 2}},
			'{'{K_UPD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF}, 1,
				'{0, 32'h0, 0, 4, 2}},
			'{'{K_PRED, 32'h8, 32'h0, 1'b0, 32'h0}, 0, none},
			'{'{K_UPD, 32'h8, 32'h1234_5678, 1'b1, 32'h1234_5678}, 0, none},
			'{'{K_UPD, 32'h8, 32'h1234_5678, 1'b1, 32'h0}, 0, none},
			'{'{K_PRED, 32'h8, 32'h0, 1'b0, 32'h0}, 0, none},
			'{'{K_UPD, 32'h8, 32'h1234_5678, 1'b1, 32'h1234_5678}, 0, none},
			'{'{K_PRED, 32'h8, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF}, 0, none},
			'{'{K_UPD, 32'h8, 32'h0, 1'b0, 32'hC}, 0, none},
			'{'{K_UPD, 32'h8, 32'h0, 1'b0, 32'hC}, 0, none},
			'{'{K_UPD, 32'h8, 32'h0, 1'b0, 32'hC}, 0, none},
			'{'{K_PRED, 32'h8, 32'h0, 1'b0, 32'h0}, 0, none},
			'{'{K_PRED, 32'hAAAA_5555, 32'h5555_AAAA, 1'b1, 32'hAAAA_5555}, 0, none}
		};
		settings[0] = '{8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1};
		settings[1] = '{8'd5, 8'd30, 8'd8, 8'd0, 8'd0, 8'd0, 8'd3};
		settings[2] = '{8'd3, 8'd4, 8'd4, 8'd1, 8'd1, 8'd1, 8'd0};
		settings[3] = '{8'd2, 8'd8, 8'd3, 8'd0, 8'd1, 8'd2, 8'd2};
		// Out-of-range values: index and tag saturate, history too long, share mode 3.
		settings[4] = '{8'hFF, 8'hFF, 8'd15, 8'hFF, 8'hFE, 8'hFF, 8'd1};
		settings[5] = '{8'd6, 8'd0, 8'd0, 8'd1, 8'd1, 8'd3, 8'd3};
		settings[6] = '{8'd4, 8'd12, 8'd9, 8'd0, 8'd1, 8'd1, 8'd2};
		settings[7] = '{8'd1, 8'd2, 8'd2, 8'd1, 8'd1, 8'd2, 8'd0};

		sh_index_bits = 3'd0;
		sh_tag_bits = 5'd0;
		sh_hist_bits = 4'd1;
		sh_global_hist = 1'b0;
		sh_global_tab = 1'b0;
		sh_share_mode = btb2l_pkg::SHARE_HIST;
		sh_init_ctr = 2'd1;
		sh_branches = '0;
		sh_flushes = '0;
		reload_tables();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) send_branch(rows[i].item, rows[i].known, rows[i].res);

		for (int ph = 1; ph < PHASES; ph++) begin
			drain_results();
			for (int r = 0; r < 7; r++) write_register(3'(r), settings[ph][r]);
			if (ph == 4) write_register(UNUSED_REG, 8'($urandom));
			cfg_valid <= 1'b0;
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 50; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 50; end
				default: begin idle_pct = 23; stall_pct = 23; end
			endcase
			for (int p = 0; p < POOL; p++) begin
				pc_pool[p] = $urandom;
				tgt_pool[p] = $urandom;
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// A long receiver hold-off while items keep coming fills the block.
				if (ph == 1 && k == 20) hold_req = 1'b1;
				// Once the sender waits until everything has come back.
				if (ph == 3 && k == 40) begin
					s_tvalid <= 1'b0;
					@(negedge clk);
					while (pending_results.size() != 0) @(negedge clk);
				end
				it = make_branch();
				send_branch(it, 1'b0, none);
			end
		end

		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0) begin
			$display("btb_two_level_branch_predictor_unit test passed");
		end else begin
			$display("btb_two_level_branch_predictor_unit test failed");
		end
		$finish;
	end

endmodule
